/* rtl/sweep_best_direction_picker_defines.svh */
// assertion macros for the rtl
`ifndef SWEEP_BEST_DIRECTION_PICKER_DEFINES_SVH
`define SWEEP_BEST_DIRECTION_PICKER_DEFINES_SVH

// same-cycle implication
`define SBDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sbdp_pkg.sv */
package sbdp_pkg;

	typedef logic [15:0]        distance_t;
	typedef logic signed [7:0]  angle_t;
	typedef logic [17:0]        wsum_t;

	localparam int FULL_ARC  = 180;
	localparam int ARC_START = -90;

	// floor(x / 3) = (x * ceil(2^19 / 3)) >> 19 for every 18-bit x
	localparam logic [17:0] DIV3_MULT  = 18'd174763;
	localparam int          DIV3_SHIFT = 19;

endpackage

/* rtl/sbdp_ifs.sv */
interface sbdp_cfg_if import sbdp_pkg::*; ();
	logic      valid;
	logic      ready;
	distance_t turn_threshold;

	modport source (output valid, output turn_threshold, input ready);
	modport sink   (input valid, input turn_threshold, output ready);
endinterface

interface sbdp_reading_if import sbdp_pkg::*; ();
	logic      valid;
	logic      ready;
	distance_t distance_cm;

	modport source (output valid, output distance_cm, input ready);
	modport sink   (input valid, input distance_cm, output ready);
endinterface

interface sbdp_result_if import sbdp_pkg::*; ();
	logic      valid;
	logic      ready;
	angle_t    turn_angle;
	distance_t best_average;
	logic      turn_request;

	modport source (output valid, output turn_angle, output best_average,
		output turn_request, input ready);
	modport sink   (input valid, input turn_angle, input best_average,
		input turn_request, output ready);
endinterface

/* rtl/sbdp_div3.sv */
module sbdp_div3 import sbdp_pkg::*; (
	input  wsum_t     sum,
	output distance_t avg
);

	logic [35:0] prod;

	// reciprocal multiply, truncating
	assign prod = 36'(sum) * 36'(DIV3_MULT);
	assign avg  = prod[DIV3_SHIFT +: 16];

endmodule

/* rtl/sweep_best_direction_picker.sv */
// result: a sweep's last reading goes through the reading and result registers
// throughput: one reading per cycle; stalls only while a finished result is not taken
// stages: reading register with window sum, then divide-by-3 and best tracking into result
// reset: arst_n low clears history, position, best average (0) and angle (-90 degrees)
// reset: turn threshold returns to 50, all valid flags clear
`include "sweep_best_direction_picker_defines.svh"

module sweep_best_direction_picker import sbdp_pkg::*; #(
	parameter int READINGS_PER_SWEEP = 19
) (
	input  logic           clk,
	input  logic           arst_n,
	sbdp_cfg_if.sink       cfg,
	sbdp_reading_if.sink   reading,
	sbdp_result_if.source  result
);

	localparam int POS_W = $clog2(READINGS_PER_SWEEP);
	localparam int STEP  = FULL_ARC / (READINGS_PER_SWEEP - 1);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(READINGS_PER_SWEEP - 1);

	distance_t        safe_q;
	distance_t        hist0_q;
	distance_t        hist1_q;
	logic [POS_W-1:0] pos_q;
	distance_t        best_q;
	angle_t           best_angle_q;

	logic   valid_s1;
	logic   last_s1;
	logic   has_avg_s1;
	wsum_t  sum_s1;
	angle_t angle_s1;

	logic      out_valid_q;
	angle_t    out_angle_q;
	distance_t out_avg_q;
	logic      out_req_q;

	logic      accept;
	logic      out_free;
	logic      adv_s1;
	logic      last_in;
	logic [11:0] ang_prod;
	angle_t    angle_in;
	distance_t avg_s1;
	logic      take;
	distance_t best_next;
	angle_t    angle_next;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_q <= 16'd50;
		end else if (cfg.valid) begin
			safe_q <= cfg.turn_threshold;
		end
	end

	assign out_free      = !out_valid_q || result.ready;
	assign adv_s1        = valid_s1 && (!last_s1 || out_free);
	assign reading.ready = !valid_s1 || adv_s1;
	assign accept        = reading.valid && reading.ready;
	assign last_in       = (pos_q >= LAST_POS);

	// angle of the window center for the incoming reading
	assign ang_prod = 12'(pos_q - POS_W'(1)) * 12'(STEP);
	assign angle_in = 8'(ang_prod + 12'(ARC_START));

	// history and position advance with each input transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q <= '0;
			hist1_q <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			hist0_q <= reading.distance_cm;
			hist1_q <= hist0_q;
			pos_q   <= last_in ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (reading.ready) begin
			valid_s1 <= reading.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1     <= 18'(hist1_q) + 18'(hist0_q) + 18'(reading.distance_cm);
			has_avg_s1 <= (pos_q >= POS_W'(2));
			last_s1    <= last_in;
			angle_s1   <= angle_in;
		end
	end

	sbdp_div3 u_div3 (
		.sum (sum_s1),
		.avg (avg_s1)
	);

	assign take       = has_avg_s1 && (avg_s1 > best_q);
	assign best_next  = take ? avg_s1 : best_q;
	assign angle_next = take ? angle_s1 : best_angle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q       <= '0;
			best_angle_q <= 8'(ARC_START);
		end else if (adv_s1) begin
			if (last_s1) begin
				best_q       <= '0;
				best_angle_q <= 8'(ARC_START);
			end else begin
				best_q       <= best_next;
				best_angle_q <= angle_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			out_angle_q <= angle_next;
			out_avg_q   <= best_next;
			out_req_q   <= (best_next < safe_q);
		end
	end

	assign result.valid        = out_valid_q;
	assign result.turn_angle   = out_angle_q;
	assign result.best_average = out_avg_q;
	assign result.turn_request = out_req_q;

	`SBDP_ASSERT_NOW(a_pos_range, clk, arst_n, 1'b1, pos_q <= LAST_POS, "position out of range")
	`SBDP_ASSERT_NOW(a_result_origin, clk, arst_n, $rose(result.valid), $past(adv_s1 && last_s1), "result without sweep end")
	`SBDP_ASSERT_NOW(a_stall_cause, clk, arst_n, valid_s1 && !adv_s1, last_s1 && out_valid_q && !result.ready, "stage stalled without cause")

endmodule
